/* rtl/bbrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bbrc_pkg;

    // band capacity and per-band curve counter width
    localparam int MAX_BAND_CURVES = 256;
    localparam int CNT_W           = $clog2(MAX_BAND_CURVES + 1);

    // iterative divide / square root unit sizes
    localparam int IT_NW         = 52;   // dividend or radicand bits
    localparam int IT_DW         = 27;   // divisor magnitude bits
    localparam int IT_RW         = 28;   // partial remainder bits
    localparam int IT_SW         = 26;   // square root bits
    localparam int IT_CNT_W      = 6;
    localparam int IT_DIV_STEPS  = IT_NW;
    localparam int IT_SQRT_STEPS = IT_NW / 2;

    // sign code lookup for root eligibility
    localparam logic [15:0] ROOT_CODE = 16'h2E74;

    // configuration
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PPU_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PPU_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST = 2'd2;
    localparam logic [31:0] PPU_RST = 32'h0100_0000;

    // item kinds
    localparam logic [1:0] KIND_HORIZ = 2'd0;
    localparam logic [1:0] KIND_VERT  = 2'd1;

    // stream widths
    localparam int COORD_W  = 24;
    localparam int IN_DW    = 8 * COORD_W;
    localparam int COV_W    = 17;
    localparam int OUT_DW   = 24;

    // iterative unit operations
    localparam logic [2:0] OP_SQ_DISC = 3'd0;
    localparam logic [2:0] OP_DIV_LIN = 3'd1;
    localparam logic [2:0] OP_DIV_T0  = 3'd2;
    localparam logic [2:0] OP_DIV_T1  = 3'd3;
    localparam logic [2:0] OP_DIV_CMB = 3'd4;
    localparam logic [2:0] OP_SQ_OUT  = 3'd5;

    // datapath steps
    localparam logic [3:0] ST_NONE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_COUNT = 4'd2;
    localparam logic [3:0] ST_ZERO  = 4'd3;
    localparam logic [3:0] ST_DISC  = 4'd4;
    localparam logic [3:0] ST_TMUL1 = 4'd5;
    localparam logic [3:0] ST_TMUL2 = 4'd6;
    localparam logic [3:0] ST_TFIN  = 4'd7;
    localparam logic [3:0] ST_RMUL  = 4'd8;
    localparam logic [3:0] ST_RFIN  = 4'd9;
    localparam logic [3:0] ST_ACC   = 4'd10;
    localparam logic [3:0] ST_CMUL  = 4'd11;
    localparam logic [3:0] ST_CSEL  = 4'd12;
    localparam logic [3:0] ST_CLEAR = 4'd13;

    typedef struct packed {
        logic       load;
        logic       it_start;
        logic [2:0] op;
        logic [3:0] step;
        logic       root;
    } t_cmd;

    typedef struct packed {
        logic elig;
        logic stop_hit;
        logic use1;
        logic use2;
        logic aq_zero;
        logic bq_zero;
        logic it_done;
        logic eos;
        logic boost;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/bezier_band_ray_coverage_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// one item at a time; a curve on the quadratic path uses a 26-step square root and two 52-step
//   divides in the shared iterative unit, a linear curve one 52-step divide, and a degenerate,
//   skipped or non-curve item no divide
// an item that ends the sample adds a 52-step divide, plus a 26-step square root when that is on,
//   then the result waits in its output register, holding off input until taken
// synchronous active-low reset: sums, weights, band stop flags and counts clear, registers
//   return to 1.0 pixel per unit and square root on

module bezier_band_ray_coverage_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write
    input  wire                                  i_cfg_we,
    input  wire [bbrc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [bbrc_pkg::CFG_DW-1:0]           i_cfg_data,
    // curve items
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_x, sample_y, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
    input  wire [bbrc_pkg::IN_DW-1:0]            s_axis_tdata,
    // kind
    input  wire [1:0]                            s_axis_tuser,
    // end_of_sample
    input  wire                                  s_axis_tlast,
    // coverage results
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // coverage, zero filled above
    output logic [bbrc_pkg::OUT_DW-1:0]          m_axis_tdata
);

    bbrc_pkg::t_cmd             cmd;
    bbrc_pkg::t_sts             sts;
    logic [bbrc_pkg::COV_W-1:0] coverage;

    bbrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    bbrc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (s_axis_tdata),
        .i_kind     (s_axis_tuser),
        .i_eos      (s_axis_tlast),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_coverage (coverage)
    );

    assign m_axis_tdata = bbrc_pkg::OUT_DW'(coverage);

endmodule

`default_nettype wire

/* rtl/bbrc_iter.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbrc_iter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire                          i_sqrt,
    input  wire [bbrc_pkg::IT_NW-1:0]    i_num,
    input  wire [bbrc_pkg::IT_DW-1:0]    i_den,
    output logic                         o_done,
    output logic [bbrc_pkg::IT_NW-1:0]   o_result,
    output logic                         o_rem_nz
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic                           r_sqrt, n_sqrt;
    logic [bbrc_pkg::IT_CNT_W-1:0]  r_cnt, n_cnt;
    logic [bbrc_pkg::IT_NW-1:0]     r_q, n_q;
    logic [bbrc_pkg::IT_RW-1:0]     r_rem, n_rem;
    logic [bbrc_pkg::IT_SW-1:0]     r_root, n_root;
    logic [bbrc_pkg::IT_DW-1:0]     r_den, n_den;

    logic [bbrc_pkg::IT_RW-1:0]     div_sh;
    logic                           div_ge;
    logic [bbrc_pkg::IT_RW+1:0]     sq_sh;
    logic [bbrc_pkg::IT_RW+1:0]     sq_trial;
    logic                           sq_ge;
    logic [bbrc_pkg::IT_RW+1:0]     sq_diff;

    // one quotient bit or one root bit per cycle
    always_comb begin
        div_sh   = {r_rem[bbrc_pkg::IT_RW-2:0], r_q[bbrc_pkg::IT_NW-1]};
        div_ge   = div_sh >= {1'b0, r_den};
        sq_sh    = {r_rem, r_q[bbrc_pkg::IT_NW-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        sq_diff  = sq_sh - sq_trial;

        n_busy = r_busy;
        n_done = 1'b0;
        n_sqrt = r_sqrt;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_root = r_root;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_sqrt = i_sqrt;
            n_q    = i_num;
            n_rem  = '0;
            n_root = '0;
            n_den  = i_den;
            n_cnt  = i_sqrt ? bbrc_pkg::IT_CNT_W'(bbrc_pkg::IT_SQRT_STEPS - 1)
                            : bbrc_pkg::IT_CNT_W'(bbrc_pkg::IT_DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_sqrt) begin
                n_rem  = sq_ge ? sq_diff[bbrc_pkg::IT_RW-1:0] : sq_sh[bbrc_pkg::IT_RW-1:0];
                n_root = {r_root[bbrc_pkg::IT_SW-2:0], sq_ge};
                n_q    = {r_q[bbrc_pkg::IT_NW-3:0], 2'b00};
            end else begin
                n_rem = div_ge ? (div_sh - {1'b0, r_den}) : div_sh;
                n_q   = {r_q[bbrc_pkg::IT_NW-2:0], div_ge};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_sqrt <= n_sqrt;
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_den  <= n_den;
    end

    assign o_done   = r_done;
    assign o_result = r_sqrt ? bbrc_pkg::IT_NW'(r_root) : r_q;
    assign o_rem_nz = |r_rem;

endmodule

`default_nettype wire

/* rtl/bbrc_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbrc_dpath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [bbrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [bbrc_pkg::CFG_DW-1:0]          i_cfg_data,
    input  wire [bbrc_pkg::IN_DW-1:0]           i_data,
    input  wire [1:0]                           i_kind,
    input  wire                                 i_eos,
    input  bbrc_pkg::t_cmd                      i_cmd,
    output bbrc_pkg::t_sts                      o_sts,
    output logic [bbrc_pkg::COV_W-1:0]          o_coverage
);

    localparam logic signed [57:0] STOP_LIM = -58'sd2147483648;
    localparam logic signed [52:0] T_LIM    = 53'sd67108864;
    localparam logic signed [37:0] E_LIM    = 38'sd1073741824;
    localparam logic signed [29:0] SUM_MAX  = 30'sd134217727;
    localparam logic signed [29:0] SUM_MIN  = -30'sd134217728;
    localparam logic signed [64:0] R_HI     = 65'sd32768;
    localparam logic signed [64:0] R_LO     = -65'sd32768;
    localparam logic [16:0]        ONE_Q16  = 17'h10000;

    // configuration
    logic [31:0] r_ppu_x, r_ppu_y;
    logic        r_boost;

    // sample state
    logic signed [27:0]         r_sum_h, r_sum_v;
    logic [16:0]                r_wmax_h, r_wmax_v;
    logic                       r_stop_h, r_stop_v;
    logic [bbrc_pkg::CNT_W-1:0] r_cnt_h, r_cnt_v;

    // item and curve working registers
    logic [1:0]         r_kind;
    logic               r_eos;
    logic signed [24:0] r_px [3];
    logic signed [24:0] r_py [3];
    logic               r_elig, r_stop_hit, r_use1, r_use2;
    logic signed [27:0] r_aq, r_ae;
    logic signed [26:0] r_bq, r_be;
    logic signed [24:0] r_q0, r_e0;
    logic signed [53:0] r_m1;
    logic signed [52:0] r_m2;
    logic [25:0]        r_d;
    logic [2:0]         r_op;
    logic               r_neg;
    logic signed [27:0] r_t [2];
    logic signed [55:0] r_p1;
    logic signed [60:0] r_p2;
    logic signed [31:0] r_ev [2];
    logic signed [64:0] r_p3;
    logic [16:0]        r_cov [2];
    logic [16:0]        r_wgt [2];
    logic signed [45:0] r_ph, r_pv;
    logic [17:0]        r_wsum;
    logic [44:0]        r_wq;
    logic [16:0]        r_res;

    // band selection
    logic               vert;
    logic [31:0]        scale;
    logic signed [24:0] ac [3];
    logic signed [24:0] al [3];
    logic signed [24:0] mx;
    logic signed [57:0] stop_prod;
    logic [2:0]         sgn;
    logic [15:0]        code;
    logic               band_stop;
    logic [bbrc_pkg::CNT_W-1:0] band_cnt;

    always_comb begin
        vert  = (r_kind == bbrc_pkg::KIND_VERT);
        scale = vert ? r_ppu_y : r_ppu_x;
        for (int k = 0; k < 3; k++) begin
            ac[k] = vert ? r_px[k] : r_py[k];
            al[k] = vert ? r_py[k] : r_px[k];
        end
        mx = al[0];
        if (al[1] > mx) mx = al[1];
        if (al[2] > mx) mx = al[2];
        stop_prod = mx * $signed({1'b0, scale});
        sgn       = {ac[2][24], ac[1][24], ac[0][24]};
        code      = bbrc_pkg::ROOT_CODE >> sgn;
        band_stop = vert ? r_stop_v : r_stop_h;
        band_cnt  = vert ? r_cnt_v : r_cnt_h;
    end

    // iterative unit operands
    logic                       it_done, it_rem_nz;
    logic [bbrc_pkg::IT_NW-1:0] it_res;
    logic [bbrc_pkg::IT_NW-1:0] it_num;
    logic [bbrc_pkg::IT_DW-1:0] it_den;
    logic                       it_neg;
    logic signed [54:0]         disc;
    logic [24:0]                q0_mag;
    logic signed [27:0]         bq2, bmd, bpd;
    logic [27:0]                bq2_mag, aq_mag, bmd_mag, bpd_mag;
    logic signed [46:0]         csum;
    logic [46:0]                csum_mag;

    always_comb begin
        disc     = 55'(r_m1) - 55'(r_m2);
        q0_mag   = r_q0[24] ? 25'(-r_q0) : 25'(r_q0);
        bq2      = 28'(r_bq) <<< 1;
        bq2_mag  = bq2[27] ? 28'(-bq2) : 28'(bq2);
        aq_mag   = r_aq[27] ? 28'(-r_aq) : 28'(r_aq);
        bmd      = 28'(r_bq) - $signed({2'b00, r_d});
        bpd      = 28'(r_bq) + $signed({2'b00, r_d});
        bmd_mag  = bmd[27] ? 28'(-bmd) : 28'(bmd);
        bpd_mag  = bpd[27] ? 28'(-bpd) : 28'(bpd);
        csum     = 47'(r_ph) + 47'(r_pv);
        csum_mag = csum[46] ? 47'(-csum) : 47'(csum);

        it_num = '0;
        it_den = '0;
        it_neg = 1'b0;
        case (i_cmd.op)
            bbrc_pkg::OP_SQ_DISC: begin
                it_num = disc[54] ? '0 : disc[bbrc_pkg::IT_NW-1:0];
            end
            bbrc_pkg::OP_DIV_LIN: begin
                it_num = bbrc_pkg::IT_NW'({q0_mag, 24'd0});
                it_den = bq2_mag[bbrc_pkg::IT_DW-1:0];
                it_neg = r_q0[24] ^ r_bq[26];
            end
            bbrc_pkg::OP_DIV_T0: begin
                it_num = bbrc_pkg::IT_NW'({bmd_mag[26:0], 24'd0});
                it_den = aq_mag[bbrc_pkg::IT_DW-1:0];
                it_neg = bmd[27] ^ r_aq[27];
            end
            bbrc_pkg::OP_DIV_T1: begin
                it_num = bbrc_pkg::IT_NW'({bpd_mag[26:0], 24'd0});
                it_den = aq_mag[bbrc_pkg::IT_DW-1:0];
                it_neg = bpd[27] ^ r_aq[27];
            end
            bbrc_pkg::OP_DIV_CMB: begin
                it_num = bbrc_pkg::IT_NW'(csum_mag);
                it_den = (r_wsum == '0) ? bbrc_pkg::IT_DW'(1) : bbrc_pkg::IT_DW'(r_wsum);
            end
            bbrc_pkg::OP_SQ_OUT: begin
                it_num = bbrc_pkg::IT_NW'({r_res, 16'd0});
            end
            default: begin
                it_num = '0;
            end
        endcase
    end

    bbrc_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.it_start),
        .i_sqrt   (i_cmd.op == bbrc_pkg::OP_SQ_DISC || i_cmd.op == bbrc_pkg::OP_SQ_OUT),
        .i_num    (it_num),
        .i_den    (it_den),
        .o_done   (it_done),
        .o_result (it_res),
        .o_rem_nz (it_rem_nz)
    );

    // floor quotient, saturated to the ray parameter range
    logic signed [52:0] qs;
    logic signed [27:0] t_sat;

    always_comb begin
        qs = r_neg ? (-$signed({1'b0, it_res}) - $signed({52'd0, it_rem_nz}))
                   : $signed({1'b0, it_res});
        if (qs > T_LIM)
            t_sat = 28'(T_LIM);
        else if (qs < -T_LIM)
            t_sat = 28'(-T_LIM);
        else
            t_sat = 28'(qs);
    end

    // crossing and root terms
    logic signed [27:0] tk;
    logic signed [32:0] inner;
    logic signed [37:0] ev_full;
    logic signed [31:0] ev_sat;
    logic signed [64:0] r16;
    logic [16:0]        r_mag, cov, wgt;

    always_comb begin
        tk      = i_cmd.root ? r_t[1] : r_t[0];
        inner   = 33'(r_p1 >>> 24) - (33'(r_be) <<< 1);
        ev_full = 38'(r_p2 >>> 24) + 38'(r_e0);
        if (ev_full > E_LIM)
            ev_sat = 32'(E_LIM);
        else if (ev_full < -E_LIM)
            ev_sat = 32'(-E_LIM);
        else
            ev_sat = 32'(ev_full);
        r16   = r_p3 >>> 16;
        r_mag = r16[64] ? 17'(-r16[16:0]) : r16[16:0];
        if (r16 >= R_HI)
            cov = ONE_Q16;
        else if (r16 < R_LO)
            cov = '0;
        else
            cov = r16[16:0] + 17'd32768;
        if (r16 > R_LO && r16 < R_HI)
            wgt = ONE_Q16 - {r_mag[15:0], 1'b0};
        else
            wgt = '0;
    end

    // band accumulation
    logic signed [18:0] c0s, c1s, delta;
    logic signed [29:0] sum_x;
    logic signed [27:0] sum_new;
    logic [16:0]        wm_new;

    always_comb begin
        c0s   = $signed({2'b00, r_cov[0]});
        c1s   = $signed({2'b00, r_cov[1]});
        delta = '0;
        if (r_use1) delta = delta + (vert ? -c0s : c0s);
        if (r_use2) delta = delta + (vert ? c1s : -c1s);
        sum_x = 30'(vert ? r_sum_v : r_sum_h) + 30'(delta);
        if (sum_x > SUM_MAX)
            sum_new = 28'(SUM_MAX);
        else if (sum_x < SUM_MIN)
            sum_new = 28'(SUM_MIN);
        else
            sum_new = 28'(sum_x);
        wm_new = vert ? r_wmax_v : r_wmax_h;
        if (r_use1 && r_wgt[0] > wm_new) wm_new = r_wgt[0];
        if (r_use2 && r_wgt[1] > wm_new) wm_new = r_wgt[1];
    end

    // final selection
    logic [27:0] ax, ay, cons;
    logic [44:0] best;

    always_comb begin
        ax   = r_sum_h[27] ? 28'(-r_sum_h) : 28'(r_sum_h);
        ay   = r_sum_v[27] ? 28'(-r_sum_v) : 28'(r_sum_v);
        cons = (ax < ay) ? ax : ay;
        best = (r_wq > 45'(cons)) ? r_wq : 45'(cons);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppu_x <= bbrc_pkg::PPU_RST;
            r_ppu_y <= bbrc_pkg::PPU_RST;
            r_boost <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bbrc_pkg::REG_PPU_X: r_ppu_x <= i_cfg_data;
                bbrc_pkg::REG_PPU_Y: r_ppu_y <= i_cfg_data;
                bbrc_pkg::REG_BOOST: r_boost <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sample accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.step == bbrc_pkg::ST_CLEAR) begin
            r_sum_h  <= '0;
            r_sum_v  <= '0;
            r_wmax_h <= '0;
            r_wmax_v <= '0;
            r_stop_h <= 1'b0;
            r_stop_v <= 1'b0;
            r_cnt_h  <= '0;
            r_cnt_v  <= '0;
        end else if (i_cmd.step == bbrc_pkg::ST_COUNT) begin
            if (vert) begin
                r_cnt_v  <= r_cnt_v + 1'b1;
                r_stop_v <= r_stop_hit;
            end else begin
                r_cnt_h  <= r_cnt_h + 1'b1;
                r_stop_h <= r_stop_hit;
            end
        end else if (i_cmd.step == bbrc_pkg::ST_ACC) begin
            if (vert) begin
                r_sum_v  <= sum_new;
                r_wmax_v <= wm_new;
            end else begin
                r_sum_h  <= sum_new;
                r_wmax_h <= wm_new;
            end
        end
    end

    // item capture, shifted to the sample point
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_eos  <= i_eos;
            for (int k = 0; k < 3; k++) begin
                r_px[k] <= 25'($signed(i_data[48*k+48 +: 24])) - 25'($signed(i_data[23:0]));
                r_py[k] <= 25'($signed(i_data[48*k+72 +: 24])) - 25'($signed(i_data[47:24]));
            end
        end
    end

    // curve working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.it_start) begin
            r_op  <= i_cmd.op;
            r_neg <= it_neg;
        end
        if (it_done) begin
            case (r_op)
                bbrc_pkg::OP_SQ_DISC: r_d <= it_res[25:0];
                bbrc_pkg::OP_DIV_LIN: begin
                    r_t[0] <= t_sat;
                    r_t[1] <= t_sat;
                end
                bbrc_pkg::OP_DIV_T0:  r_t[0] <= t_sat;
                bbrc_pkg::OP_DIV_T1:  r_t[1] <= t_sat;
                bbrc_pkg::OP_DIV_CMB: r_wq <= it_res[44:0];
                bbrc_pkg::OP_SQ_OUT:  r_res <= it_res[16:0];
                default: ;
            endcase
        end
        case (i_cmd.step)
            bbrc_pkg::ST_CHECK: begin
                r_elig     <= (r_kind == bbrc_pkg::KIND_HORIZ || r_kind == bbrc_pkg::KIND_VERT)
                              && !band_stop
                              && (band_cnt < bbrc_pkg::CNT_W'(bbrc_pkg::MAX_BAND_CURVES));
                r_stop_hit <= stop_prod < STOP_LIM;
                r_use1     <= code[0];
                r_use2     <= code[8];
                r_aq       <= 28'(ac[0]) - (28'(ac[1]) <<< 1) + 28'(ac[2]);
                r_bq       <= 27'(ac[0]) - 27'(ac[1]);
                r_ae       <= 28'(al[0]) - (28'(al[1]) <<< 1) + 28'(al[2]);
                r_be       <= 27'(al[0]) - 27'(al[1]);
                r_q0       <= ac[0];
                r_e0       <= al[0];
            end
            bbrc_pkg::ST_DISC: begin
                r_m1 <= r_bq * r_bq;
                r_m2 <= r_aq * r_q0;
            end
            bbrc_pkg::ST_ZERO: begin
                r_ev[0] <= '0;
                r_ev[1] <= '0;
            end
            bbrc_pkg::ST_TMUL1: r_p1 <= r_ae * tk;
            bbrc_pkg::ST_TMUL2: r_p2 <= inner * tk;
            bbrc_pkg::ST_TFIN:  r_ev[i_cmd.root] <= ev_sat;
            bbrc_pkg::ST_RMUL:  r_p3 <= r_ev[i_cmd.root] * $signed({1'b0, scale});
            bbrc_pkg::ST_RFIN: begin
                r_cov[i_cmd.root] <= cov;
                r_wgt[i_cmd.root] <= wgt;
            end
            bbrc_pkg::ST_CMUL: begin
                r_ph   <= r_sum_h * $signed({1'b0, r_wmax_h});
                r_pv   <= r_sum_v * $signed({1'b0, r_wmax_v});
                r_wsum <= 18'(r_wmax_h) + 18'(r_wmax_v);
            end
            bbrc_pkg::ST_CSEL: begin
                r_res <= (best > 45'(ONE_Q16)) ? ONE_Q16 : best[16:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.elig     = r_elig;
        o_sts.stop_hit = r_stop_hit;
        o_sts.use1     = r_use1;
        o_sts.use2     = r_use2;
        o_sts.aq_zero  = (r_aq == '0);
        o_sts.bq_zero  = (r_bq == '0);
        o_sts.it_done  = it_done;
        o_sts.eos      = r_eos;
        o_sts.boost    = r_boost;
    end

    assign o_coverage = r_res;

endmodule

`default_nettype wire

/* rtl/bbrc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbrc_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_out_ready,
    input  bbrc_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output bbrc_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CHECK   = 5'd1;
    localparam logic [4:0] S_DECIDE  = 5'd2;
    localparam logic [4:0] S_ZERO    = 5'd3;
    localparam logic [4:0] S_LIN_GO  = 5'd4;
    localparam logic [4:0] S_LIN_W   = 5'd5;
    localparam logic [4:0] S_DISC    = 5'd6;
    localparam logic [4:0] S_SQ_GO   = 5'd7;
    localparam logic [4:0] S_SQ_W    = 5'd8;
    localparam logic [4:0] S_D0_GO   = 5'd9;
    localparam logic [4:0] S_D0_W    = 5'd10;
    localparam logic [4:0] S_D1_GO   = 5'd11;
    localparam logic [4:0] S_D1_W    = 5'd12;
    localparam logic [4:0] S_TMUL1   = 5'd13;
    localparam logic [4:0] S_TMUL2   = 5'd14;
    localparam logic [4:0] S_TFIN    = 5'd15;
    localparam logic [4:0] S_RMUL    = 5'd16;
    localparam logic [4:0] S_RFIN    = 5'd17;
    localparam logic [4:0] S_ACC     = 5'd18;
    localparam logic [4:0] S_END     = 5'd19;
    localparam logic [4:0] S_CMUL    = 5'd20;
    localparam logic [4:0] S_CD_GO   = 5'd21;
    localparam logic [4:0] S_CD_W    = 5'd22;
    localparam logic [4:0] S_CSEL    = 5'd23;
    localparam logic [4:0] S_CS_GO   = 5'd24;
    localparam logic [4:0] S_CS_W    = 5'd25;
    localparam logic [4:0] S_OUT     = 5'd26;

    logic [4:0] r_state, n_state;
    logic       r_root, n_root;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_root      = r_root;
        o_cmd       = '0;
        o_cmd.root  = r_root;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.step = bbrc_pkg::ST_CHECK;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                n_root = 1'b0;
                if (!i_sts.elig) begin
                    n_state = S_END;
                end else begin
                    o_cmd.step = bbrc_pkg::ST_COUNT;
                    if (i_sts.stop_hit || !(i_sts.use1 || i_sts.use2))
                        n_state = S_END;
                    else if (i_sts.aq_zero)
                        n_state = i_sts.bq_zero ? S_ZERO : S_LIN_GO;
                    else
                        n_state = S_DISC;
                end
            end
            S_ZERO: begin
                o_cmd.step = bbrc_pkg::ST_ZERO;
                n_state    = S_RMUL;
            end
            S_LIN_GO: begin
                o_cmd.it_start = 1'b1;
                o_cmd.op       = bbrc_pkg::OP_DIV_LIN;
                n_state        = S_LIN_W;
            end
            S_LIN_W: begin
                if (i_sts.it_done) n_state = S_TMUL1;
            end
            S_DISC: begin
                o_cmd.step = bbrc_pkg::ST_DISC;
                n_state    = S_SQ_GO;
            end
            S_SQ_GO: begin
                o_cmd.it_start = 1'b1;
                o_cmd.op       = bbrc_pkg::OP_SQ_DISC;
                n_state        = S_SQ_W;
            end
            S_SQ_W: begin
                if (i_sts.it_done) n_state = S_D0_GO;
            end
            S_D0_GO: begin
                o_cmd.it_start = 1'b1;
                o_cmd.op       = bbrc_pkg::OP_DIV_T0;
                n_state        = S_D0_W;
            end
            S_D0_W: begin
                if (i_sts.it_done) n_state = S_D1_GO;
            end
            S_D1_GO: begin
                o_cmd.it_start = 1'b1;
                o_cmd.op       = bbrc_pkg::OP_DIV_T1;
                n_state        = S_D1_W;
            end
            S_D1_W: begin
                if (i_sts.it_done) n_state = S_TMUL1;
            end
            // crossing along the ray, one root at a time
            S_TMUL1: begin
                o_cmd.step = bbrc_pkg::ST_TMUL1;
                n_state    = S_TMUL2;
            end
            S_TMUL2: begin
                o_cmd.step = bbrc_pkg::ST_TMUL2;
                n_state    = S_TFIN;
            end
            S_TFIN: begin
                o_cmd.step = bbrc_pkg::ST_TFIN;
                n_root     = ~r_root;
                n_state    = r_root ? S_RMUL : S_TMUL1;
            end
            // pixel distance, coverage and weight per root
            S_RMUL: begin
                o_cmd.step = bbrc_pkg::ST_RMUL;
                n_state    = S_RFIN;
            end
            S_RFIN: begin
                o_cmd.step = bbrc_pkg::ST_RFIN;
                n_root     = ~r_root;
                n_state    = r_root ? S_ACC : S_RMUL;
            end
            S_ACC: begin
                o_cmd.step = bbrc_pkg::ST_ACC;
                n_state    = S_END;
            end
            S_END: begin
                n_state = i_sts.eos ? S_CMUL : S_IDLE;
            end
            // dual-ray combination
            S_CMUL: begin
                o_cmd.step = bbrc_pkg::ST_CMUL;
                n_state    = S_CD_GO;
            end
            S_CD_GO: begin
                o_cmd.it_start = 1'b1;
                o_cmd.op       = bbrc_pkg::OP_DIV_CMB;
                n_state        = S_CD_W;
            end
            S_CD_W: begin
                if (i_sts.it_done) n_state = S_CSEL;
            end
            S_CSEL: begin
                o_cmd.step = bbrc_pkg::ST_CSEL;
                n_state    = i_sts.boost ? S_CS_GO : S_OUT;
            end
            S_CS_GO: begin
                o_cmd.it_start = 1'b1;
                o_cmd.op       = bbrc_pkg::OP_SQ_OUT;
                n_state        = S_CS_W;
            end
            S_CS_W: begin
                if (i_sts.it_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.step = bbrc_pkg::ST_CLEAR;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
        end
    end

    // an accepted item always starts its check
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted item did not enter check");

    // the shared unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.it_done |-> (r_state == S_LIN_W || r_state == S_SQ_W || r_state == S_D0_W ||
                           r_state == S_D1_W || r_state == S_CD_W || r_state == S_CS_W))
        else $error("iterative unit finished outside a wait state");

    // a result is only offered after the combination step
    a_out_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_CSEL || $past(r_state) == S_CS_W))
        else $error("result offered without combination");

    // root index is back at zero whenever the band accumulation step is reached
    a_root_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> !r_root)
        else $error("root index not rewound after root terms");

endmodule

`default_nettype wire
